// ===== design/css_color_parser_assert.svh =====
// ----------------------------------------------------------------------------
// CSS color parser assertion macros
// Shorthands for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef CSS_COLOR_PARSER_ASSERT_SVH
`define CSS_COLOR_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CCP_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ccp_pkg.sv =====
// ----------------------------------------------------------------------------
// CSS color parser package
// Types, character codes and the fixed color name table.
// ----------------------------------------------------------------------------
package ccp_pkg;

	localparam int NAME_COUNT   = 20;
	localparam int NAME_MAX_LEN = 8;
	localparam int POS_SAT      = 8;

	typedef logic [7:0]            char_t;
	typedef logic [3:0]            pos_t;
	typedef logic [3:0]            nibble_t;
	typedef logic [1:0]            comp_cnt_t;
	typedef logic [31:0]           argb_t;
	typedef logic [2:0]            name_len_t;
	typedef logic [NAME_COUNT-1:0] name_mask_t;
	typedef logic [NAME_MAX_LEN*8-1:0] name_text_t;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	localparam char_t CH_HASH  = 8'h23;
	localparam char_t CH_0     = 8'h30;
	localparam char_t CH_9     = 8'h39;
	localparam char_t CH_UA    = 8'h41;
	localparam char_t CH_UF    = 8'h46;
	localparam char_t CH_UZ    = 8'h5A;
	localparam char_t CH_LA    = 8'h61;
	localparam char_t CH_LF    = 8'h66;
	localparam char_t CH_R     = 8'h72;
	localparam char_t CH_G     = 8'h67;
	localparam char_t CH_B     = 8'h62;
	localparam char_t CASE_OFS = 8'h20;

	// Names are right-aligned: the first character sits in the highest used byte.
	localparam name_text_t NAME_TEXT [NAME_COUNT] = '{
		64'("black"),  64'("white"),  64'("red"),     64'("green"),   64'("lime"),
		64'("blue"),   64'("navy"),   64'("gray"),    64'("grey"),    64'("silver"),
		64'("yellow"), 64'("orange"), 64'("purple"),  64'("maroon"),  64'("olive"),
		64'("teal"),   64'("aqua"),   64'("cyan"),    64'("fuchsia"), 64'("magenta")
	};

	localparam name_len_t NAME_LEN [NAME_COUNT] = '{
		3'd5, 3'd5, 3'd3, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd6,
		3'd6, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4, 3'd4, 3'd4, 3'd7, 3'd7
	};

	localparam argb_t NAME_COLOR [NAME_COUNT] = '{
		32'hFF000000, 32'hFFFFFFFF, 32'hFFFF0000, 32'hFF008000, 32'hFF00FF00,
		32'hFF0000FF, 32'hFF000080, 32'hFF808080, 32'hFF808080, 32'hFFC0C0C0,
		32'hFFFFFF00, 32'hFFFFA500, 32'hFF800080, 32'hFF800000, 32'hFF808000,
		32'hFF008080, 32'hFF00FFFF, 32'hFF00FFFF, 32'hFFFF00FF, 32'hFFFF00FF
	};

	// Hex digit decode: bit 4 flags a valid digit.
	function automatic logic [4:0] hex_decode(input char_t c);
		logic [4:0] r;
		r = 5'b0;
		if (c >= CH_0 && c <= CH_9) begin
			r = {1'b1, 4'(c - CH_0)};
		end else if (c >= CH_LA && c <= CH_LF) begin
			r = {1'b1, 4'(c - CH_LA + 8'd10)};
		end else if (c >= CH_UA && c <= CH_UF) begin
			r = {1'b1, 4'(c - CH_UA + 8'd10)};
		end
		return r;
	endfunction

endpackage

// ===== design/css_color_parser.sv =====
// ----------------------------------------------------------------------------
// CSS color parser
// Streams a CSS color value in one character per item and answers on the
// last character with an ARGB word (opaque on success, zero on failure) and a success flag.
// ----------------------------------------------------------------------------
// Path: input register, then the result register once it is free to load.
// Throughput: one character per cycle unless a last character waits on a full,
// stalled result register; the per-character state update is a single pass of
// compares and a small multiply-by-ten between the registers.
// Reset: arst_n clears all parse state and both valid flags at once.
// ----------------------------------------------------------------------------
module css_color_parser
	import ccp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  char_t char_code,
	input  logic  last,
	output logic  out_valid,
	input  logic  out_ready,
	output argb_t color,
	output logic  ok
);

	// Input register
	logic  valid_s1;
	char_t char_s1;
	logic  last_s1;

	// Parse state, per slice
	pos_t       pos_q;
	logic       hash_mode_q;
	logic       rgb_prefix_q;
	logic [23:0] hex_accum_q;
	logic       hex_bad_q;
	logic [7:0] dec_cur_q;
	logic       dec_have_q;
	comp_cnt_t  comp_cnt_q;
	logic [7:0] comp_val_q [3];
	name_mask_t cand_q;

	// Next-state values after the character in the input register
	pos_t       pos_n;
	logic       hash_mode_n;
	logic       rgb_prefix_n;
	logic [23:0] hex_accum_n;
	logic       hex_bad_n;
	logic [7:0] dec_cur_n;
	logic       dec_have_n;
	comp_cnt_t  comp_cnt_n;
	logic [7:0] comp_val_n [3];
	name_mask_t cand_n;

	// Result of the current slice, valid only when last_s1 is set
	argb_t res_color;
	logic  res_ok;

	logic  out_free;
	logic  s1_go;

	// Advance the input register when its character is not a last one
	// (no result to place) or the result register can take a new value.
	assign out_free = !out_valid || out_ready;
	assign s1_go    = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || s1_go;

	// ------------------------------------------------------------------------
	// Per-character update
	// ------------------------------------------------------------------------
	always_comb begin
		char_t       lc;
		logic [4:0]  hex;
		char_t       want;
		logic        is_digit;
		logic [11:0] dec_mul;
		logic [3:0]  ofs;
		logic        flush;
		logic [7:0]  fin [3];
		logic        found;

		lc = char_s1;
		if (char_s1 >= CH_UA && char_s1 <= CH_UZ) begin
			lc = char_s1 + CASE_OFS;
		end

		pos_n        = (pos_q < pos_t'(POS_SAT)) ? pos_q + 4'd1 : pos_t'(POS_SAT);
		hash_mode_n  = hash_mode_q;
		rgb_prefix_n = rgb_prefix_q;
		hex_accum_n  = hex_accum_q;
		hex_bad_n    = hex_bad_q;
		dec_cur_n    = dec_cur_q;
		dec_have_n   = dec_have_q;
		comp_cnt_n   = comp_cnt_q;
		comp_val_n   = comp_val_q;
		cand_n       = cand_q;

		// Form detection on the first three characters
		if (pos_q == 4'd0) begin
			hash_mode_n = (char_s1 == CH_HASH);
		end
		unique case (pos_q)
			4'd0:    want = CH_R;
			4'd1:    want = CH_G;
			default: want = CH_B;
		endcase
		if (pos_q < 4'd3 && lc != want) begin
			rgb_prefix_n = 1'b0;
		end

		// Hex digits at positions one through six
		hex = hex_decode(char_s1);
		if (pos_q >= 4'd1 && pos_q <= 4'd6) begin
			if (!hex[4]) begin
				hex_bad_n = 1'b1;
			end else begin
				hex_accum_n = {hex_accum_q[19:0], hex[3:0]};
			end
		end

		// Decimal components from position three on, saturating at 255
		is_digit = (char_s1 >= CH_0 && char_s1 <= CH_9);
		dec_mul  = ({4'b0, dec_cur_q} << 3) + ({4'b0, dec_cur_q} << 1)
			+ {8'b0, 4'(char_s1 - CH_0)};
		if (pos_q >= 4'd3 && comp_cnt_q != 2'd3) begin
			if (is_digit) begin
				dec_cur_n  = (dec_mul > 12'd255) ? 8'hFF : dec_mul[7:0];
				dec_have_n = 1'b1;
			end else if (dec_have_q) begin
				for (int i = 0; i < 3; i++) begin
					if (comp_cnt_q == 2'(i)) begin
						comp_val_n[i] = dec_cur_q;
					end
				end
				comp_cnt_n = comp_cnt_q + 2'd1;
				dec_cur_n  = 8'd0;
				dec_have_n = 1'b0;
			end
		end

		// Drop names that are too short or differ at this position
		for (int k = 0; k < NAME_COUNT; k++) begin
			ofs = {1'b0, NAME_LEN[k]} - 4'd1 - pos_q;
			if (pos_q >= {1'b0, NAME_LEN[k]}
					|| NAME_TEXT[k][{ofs[2:0], 3'b000} +: 8] != lc) begin
				cand_n[k] = 1'b0;
			end
		end

		// Result for a slice ending here
		flush = (comp_cnt_n != 2'd3) && dec_have_n;
		for (int i = 0; i < 3; i++) begin
			fin[i] = (flush && comp_cnt_n == 2'(i)) ? dec_cur_n : comp_val_n[i];
		end

		res_color = '0;
		res_ok    = 1'b0;
		found     = 1'b0;
		if (hash_mode_n) begin
			if (!hex_bad_n && pos_q == 4'd3) begin
				res_color = {ALPHA_OPAQUE,
					hex_accum_n[11:8], hex_accum_n[11:8],
					hex_accum_n[7:4],  hex_accum_n[7:4],
					hex_accum_n[3:0],  hex_accum_n[3:0]};
				res_ok = 1'b1;
			end else if (!hex_bad_n && pos_q == 4'd6) begin
				res_color = {ALPHA_OPAQUE, hex_accum_n};
				res_ok    = 1'b1;
			end
		end else if (pos_q >= 4'd3 && rgb_prefix_n) begin
			if (comp_cnt_n == 2'd3 || (comp_cnt_n == 2'd2 && flush)) begin
				res_color = {ALPHA_OPAQUE, fin[0], fin[1], fin[2]};
				res_ok    = 1'b1;
			end
		end else begin
			// First matching name wins
			for (int k = 0; k < NAME_COUNT; k++) begin
				if (!found && cand_n[k] && {1'b0, NAME_LEN[k]} == pos_q + 4'd1) begin
					res_color = NAME_COLOR[k];
					res_ok    = 1'b1;
					found     = 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Input register: hold the character until it is processed
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			last_s1 <= last;
		end
	end

	// ------------------------------------------------------------------------
	// Parse state: advance per character, clear after the last one
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			hash_mode_q  <= 1'b0;
			rgb_prefix_q <= 1'b1;
			hex_accum_q  <= '0;
			hex_bad_q    <= 1'b0;
			dec_cur_q    <= '0;
			dec_have_q   <= 1'b0;
			comp_cnt_q   <= '0;
			comp_val_q   <= '{default: '0};
			cand_q       <= '1;
		end else if (s1_go) begin
			if (last_s1) begin
				pos_q        <= '0;
				hash_mode_q  <= 1'b0;
				rgb_prefix_q <= 1'b1;
				hex_accum_q  <= '0;
				hex_bad_q    <= 1'b0;
				dec_cur_q    <= '0;
				dec_have_q   <= 1'b0;
				comp_cnt_q   <= '0;
				comp_val_q   <= '{default: '0};
				cand_q       <= '1;
			end else begin
				pos_q        <= pos_n;
				hash_mode_q  <= hash_mode_n;
				rgb_prefix_q <= rgb_prefix_n;
				hex_accum_q  <= hex_accum_n;
				hex_bad_q    <= hex_bad_n;
				dec_cur_q    <= dec_cur_n;
				dec_have_q   <= dec_have_n;
				comp_cnt_q   <= comp_cnt_n;
				comp_val_q   <= comp_val_n;
				cand_q       <= cand_n;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result register: load on a last character, drop once taken
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			color <= res_color;
			ok    <= res_ok;
		end
	end

endmodule

// ===== design/ccp_checker.sv =====
// ----------------------------------------------------------------------------
// CSS color parser checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "css_color_parser_assert.svh"

module ccp_checker
	import ccp_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input argb_t color,
	input logic  ok
);

	// A failed parse carries color zero.
	`CCP_ASSERT_IMPLY(a_fail_zero, out_valid && !ok, color == 32'd0, "failed item has nonzero color")

	// A recognized color is always opaque.
	`CCP_ASSERT_IMPLY(a_ok_opaque, out_valid && ok, color[31:24] == ALPHA_OPAQUE, "ok item not opaque")

	// A stalled result holds its value.
	`CCP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(color) && $stable(ok), "stalled result changed")

	// The input side only stalls behind a full, stalled result register.
	`CCP_ASSERT_IMPLY(a_ready_stall, !in_ready, out_valid && !out_ready,
		"input stalled without a stalled result")

endmodule

bind css_color_parser ccp_checker u_ccp_checker (.*);

// ===== bench/css_color_parser_tb.sv =====
// ----------------------------------------------------------------------------
// CSS color parser testbench
// Streams color text into the parser one character per item and checks every
// answer against a cycle-free parse of the same text, kept inside the bench.
// Covers the hex, rgb and named forms, broken and overlong slices, raw bytes,
// and random stalls on both handshakes.
// ----------------------------------------------------------------------------
module css_color_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ccp_pkg::*;

	localparam int HUE_TOTAL  = 20;
	localparam int RUN_ITEMS  = 1100;
	localparam int CALM_AFTER = 950;

	// Entries of the stimulus queue: characters, and marks that steer the driver.
	typedef enum logic [1:0] {
		FEED_CHAR,
		FEED_DRAIN,
		FEED_BUSY,
		FEED_QUIET
	} feed_kind_t;

	typedef struct {
		feed_kind_t kind;
		char_t      code;
		logic       fin;
	} feed_t;

	typedef struct {
		argb_t color;
		logic  ok;
	} color_result_t;

	// Color names and their ARGB words, first match wins.
	string hue_names [HUE_TOTAL] = '{
		"black", "white", "red", "green", "lime", "blue", "navy", "gray", "grey",
		"silver", "yellow", "orange", "purple", "maroon", "olive", "teal", "aqua",
		"cyan", "fuchsia", "magenta"
	};
	argb_t hue_words [HUE_TOTAL] = '{
		32'hFF000000, 32'hFFFFFFFF, 32'hFFFF0000, 32'hFF008000, 32'hFF00FF00,
		32'hFF0000FF, 32'hFF000080, 32'hFF808080, 32'hFF808080, 32'hFFC0C0C0,
		32'hFFFFFF00, 32'hFFFFA500, 32'hFF800080, 32'hFF800000, 32'hFF808000,
		32'hFF008080, 32'hFF00FFFF, 32'hFF00FFFF, 32'hFFFF00FF, 32'hFFFF00FF
	};

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  in_valid  = 1'b0;
	logic  in_ready;
	char_t char_code = 8'h00;
	logic  last      = 1'b0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	argb_t color;
	logic  ok;

	css_color_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.color     (color),
		.ok        (ok)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// Parse state of the bench's own color parser
	// ------------------------------------------------------------------------
	int unsigned   at_pos;
	bit            hash_form;
	bit            rgb_lead;
	logic [23:0]   hex_bits;
	bit            hex_broken;
	int unsigned   dec_val;
	bit            dec_any;
	int unsigned   comp_done;
	logic [7:0]    comp_val [3];
	logic [19:0]   name_live;

	color_result_t want_colors [$];
	feed_t         feed_q [$];
	char_t         text [$];
	int            char_total = 0;
	bit            bad = 1'b0;

	// Handshake bookkeeping shared between the edge processes.
	bit            char_taken = 1'b0;
	bit            draining   = 1'b0;
	bit            bursty     = 1'b1;
	int            send_gap   = 0;
	int            take_hold  = 0;
	feed_t         nxt;

	task automatic clear_parse();
		at_pos     = 0;
		hash_form  = 1'b0;
		rgb_lead   = 1'b1;
		hex_bits   = '0;
		hex_broken = 1'b0;
		dec_val    = 0;
		dec_any    = 1'b0;
		comp_done  = 0;
		comp_val   = '{8'h00, 8'h00, 8'h00};
		name_live  = '1;
	endtask

	// Advance the parse by one accepted character; on the final one, queue the
	// color the block must answer with and start over.
	task automatic parse_char(input char_t c, input logic fin);
		char_t         lc;
		int            nib;
		int unsigned   acc;
		color_result_t res;
		string         lead;
		lead = "rgb";
		lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;

		if (at_pos == 0)
			hash_form = (c == "#");
		if (at_pos < 3 && lc != lead[at_pos])
			rgb_lead = 1'b0;

		// Hex digits sit at positions 1 to 6 after the hash.
		if (at_pos >= 1 && at_pos <= 6) begin
			nib = -1;
			if (c >= "0" && c <= "9")
				nib = c - "0";
			else if (lc >= "a" && lc <= "f")
				nib = lc - "a" + 10;
			if (nib < 0)
				hex_broken = 1'b1;
			else
				hex_bits = {hex_bits[19:0], 4'(nib)};
		end

		// Decimal components start after the three prefix characters; any
		// non-digit closes a component that has digits.
		if (at_pos >= 3 && comp_done < 3) begin
			if (c >= "0" && c <= "9") begin
				acc = dec_val * 10 + (c - "0");
				dec_val = (acc > 255) ? 255 : acc;
				dec_any = 1'b1;
			end else if (dec_any) begin
				comp_val[comp_done] = 8'(dec_val);
				comp_done++;
				dec_val = 0;
				dec_any = 1'b0;
			end
		end

		// Drop names that are too short or differ at this position.
		for (int k = 0; k < HUE_TOTAL; k++) begin
			if (name_live[k] && (at_pos >= hue_names[k].len() || hue_names[k][at_pos] != lc))
				name_live[k] = 1'b0;
		end

		if (!fin) begin
			at_pos = (at_pos < 8) ? at_pos + 1 : 8;
			return;
		end

		res = '{32'h0, 1'b0};
		if (hash_form) begin
			if (!hex_broken && at_pos == 3) begin
				res.color = {8'hFF, 8'(hex_bits[11:8] * 17), 8'(hex_bits[7:4] * 17),
					8'(hex_bits[3:0] * 17)};
				res.ok = 1'b1;
			end else if (!hex_broken && at_pos == 6) begin
				res.color = {8'hFF, hex_bits};
				res.ok = 1'b1;
			end
		end else if (at_pos >= 3 && rgb_lead) begin
			if (comp_done < 3 && dec_any) begin
				comp_val[comp_done] = 8'(dec_val);
				comp_done++;
			end
			if (comp_done == 3) begin
				res.color = {8'hFF, comp_val[0], comp_val[1], comp_val[2]};
				res.ok = 1'b1;
			end
		end else begin
			for (int k = 0; k < HUE_TOTAL; k++) begin
				if (!res.ok && name_live[k] && hue_names[k].len() == at_pos + 1) begin
					res.color = hue_words[k];
					res.ok = 1'b1;
				end
			end
		end
		want_colors.push_back(res);
		clear_parse();
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic char_t flip_case(input char_t c);
		if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1))
			return c ^ 8'h20;
		return c;
	endfunction

	function automatic char_t hex_digit();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(0, 21)];
	endfunction

	function automatic char_t any_letter();
		return flip_case(char_t'("a" + $urandom_range(0, 25)));
	endfunction

	task automatic add_byte(input char_t c);
		text.push_back(c);
	endtask

	task automatic add_text(input string s, input bit mix);
		for (int j = 0; j < s.len(); j++)
			add_byte(mix ? flip_case(s[j]) : char_t'(s[j]));
	endtask

	// Move the text built so far into the feed, flagging its final character.
	task automatic end_slice();
		for (int j = 0; j < text.size(); j++)
			feed_q.push_back('{FEED_CHAR, text[j], j == text.size() - 1});
		char_total += text.size();
		text.delete();
	endtask

	task automatic push_mark(input feed_kind_t k);
		feed_q.push_back('{k, 8'h00, 1'b0});
	endtask

	// ------------------------------------------------------------------------
	// Input side: note acceptance at the rising edge and feed the parse
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			parse_char(char_code, last);
			char_taken = 1'b1;
		end
	end

	// Driver: hold an offered item until taken, then insert a gap, honor a
	// mark, or offer the next character.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !char_taken) begin
			// hold the item and its payload
		end else begin
			char_taken = 1'b0;
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (draining) begin
				// pause the sender until every pending answer is back
				in_valid <= 1'b0;
				if (want_colors.size() == 0)
					draining = 1'b0;
			end else if (feed_q.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				nxt = feed_q.pop_front();
				case (nxt.kind)
					FEED_CHAR: begin
						in_valid  <= 1'b1;
						char_code <= nxt.code;
						last      <= nxt.fin;
						if (bursty && $urandom_range(0, 5) == 0)
							send_gap = $urandom_range(1, 19);
					end
					FEED_DRAIN: begin
						in_valid <= 1'b0;
						draining = 1'b1;
					end
					FEED_BUSY: begin
						in_valid <= 1'b0;
						bursty = 1'b1;
					end
					default: begin
						in_valid <= 1'b0;
						bursty = 1'b0;
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Output side: random stall bursts, none in quiet phases
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (take_hold > 0) begin
			out_ready <= 1'b0;
			take_hold--;
		end else if (bursty && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			take_hold = $urandom_range(0, 18);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Check each accepted answer against the oldest pending one.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (want_colors.size() == 0) begin
				$display("%0t: unexpected result, expected none, got color %h ok %b",
					$time, color, ok);
				bad = 1'b1;
			end else begin
				if (color !== want_colors[0].color) begin
					$display("%0t: color mismatch, expected %h, got %h",
						$time, want_colors[0].color, color);
					bad = 1'b1;
				end
				if (ok !== want_colors[0].ok) begin
					$display("%0t: ok mismatch, expected %b, got %b",
						$time, want_colors[0].ok, ok);
					bad = 1'b1;
				end
				void'(want_colors.pop_front());
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------------
	initial begin
		int    pick;
		int    n;
		int    len;
		int    mode;
		int    flaw;
		char_t c;
		string w;
		bit    tail;

		tail = 1'b0;
		clear_parse();

		// Directed: short hex, long hex in mixed case, an rgb slice with a raw
		// byte as separator, a saturating component and an extra component,
		// a name alias, and a lone zero byte that matches nothing.
		add_text("#0F9", 1'b0);
		end_slice();
		add_text("#aB12eF", 1'b0);
		end_slice();
		add_text("rgB1", 1'b0);
		add_byte(8'hFF);
		add_text("999,0,7", 1'b0);
		end_slice();
		add_text("Grey", 1'b0);
		end_slice();
		add_byte(8'h00);
		end_slice();
		push_mark(FEED_DRAIN);

		// Random: mostly well-formed slices with random content, the rest
		// broken slices and raw noise.
		while (char_total < RUN_ITEMS) begin
			if (!tail && char_total >= CALM_AFTER) begin
				push_mark(FEED_QUIET);
				tail = 1'b1;
			end else if (!tail) begin
				if ($urandom_range(0, 14) == 0)
					push_mark($urandom_range(0, 1) ? FEED_BUSY : FEED_QUIET);
				if ($urandom_range(0, 39) == 0)
					push_mark(FEED_DRAIN);
			end

			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				// well-formed hex, three or six digits
				add_byte("#");
				n = $urandom_range(0, 1) ? 3 : 6;
				repeat (n) add_byte(hex_digit());
			end else if (pick < 30) begin
				// hex of any length, now and then a bad digit
				add_byte("#");
				n = $urandom_range(0, 9);
				repeat (n)
					add_byte(($urandom_range(0, 7) == 0) ? char_t'($urandom_range(0, 255)) :
						hex_digit());
			end else if (pick < 60) begin
				// rgb prefix, rarely spoiled, then decimal components
				w = "rgb";
				for (int j = 0; j < 3; j++) begin
					c = w[j];
					if ($urandom_range(0, 11) == 0)
						c = char_t'("a" + $urandom_range(0, 25));
					add_byte(flip_case(c));
				end
				if ($urandom_range(0, 1))
					add_byte("(");
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 3;
				for (int j = 0; j < n; j++) begin
					if (j > 0 || $urandom_range(0, 1)) begin
						repeat ($urandom_range(1, 2)) begin
							case ($urandom_range(0, 4))
								0:       add_byte(",");
								1:       add_byte(" ");
								2:       add_byte(")");
								3:       add_byte(char_t'($urandom_range(128, 255)));
								default: add_byte(any_letter());
							endcase
						end
					end
					repeat ($urandom_range(1, 4))
						add_byte(char_t'("0" + $urandom_range(0, 9)));
				end
				if ($urandom_range(0, 1))
					add_byte(")");
			end else if (pick < 85) begin
				// a color name in random case: intact, cut short, extended or
				// with one letter swapped
				w = hue_names[$urandom_range(0, HUE_TOTAL - 1)];
				mode = $urandom_range(0, 9);
				len = (mode == 7) ? $urandom_range(1, w.len() - 1) : w.len();
				flaw = (mode == 9) ? $urandom_range(0, len - 1) : -1;
				for (int j = 0; j < len; j++)
					add_byte((j == flaw) ? any_letter() : flip_case(w[j]));
				if (mode == 8)
					add_byte(any_letter());
			end else begin
				// raw bytes over the full range
				n = $urandom_range(1, 10);
				repeat (n) add_byte(char_t'($urandom_range(0, 255)));
			end
			end_slice();
		end

		// Hold reset, then release it away from the rising edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for the feed to empty, then for the last answers to drain.
		@(posedge clk);
		while (feed_q.size() != 0 || in_valid || draining)
			@(posedge clk);
		while (want_colors.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		if (!bad) begin
			$display("PASS css_color_parser");
		end else begin
			$display("FAIL css_color_parser");
		end
		$finish;
	end

	// Watchdog: a healthy run ends far sooner.
	initial begin
		#4_000_000;
		$display("FAIL css_color_parser");
		$finish;
	end

endmodule
